/* rtl/core/rip_pkg.sv */
package rip_pkg;

	localparam int POOL_SIZE_DEF = 256;
	localparam int CMD_W         = 2;
	localparam int RND_W         = 31;
	localparam int IDX_W         = 8;
	localparam int REM_W         = 9;
	localparam int DIV_CNT_W     = $clog2(RND_W + 1);

	typedef enum logic [CMD_W-1:0] {
		CMD_REFILL = 2'd0,
		CMD_DRAW   = 2'd1,
		CMD_REMOVE = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		RD_POS,
		RD_LAST,
		RD_SCAN
	} rd_sel_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DISPATCH,
		ST_REFILL,
		ST_DIV,
		ST_RD_POS,
		ST_CHECK,
		ST_SEARCH,
		ST_FETCH_LAST,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic    accept;
		logic    load_pos;
		logic    div_load;
		logic    div_step;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    scan_init;
		logic    scan_step;
		logic    capture;
		logic    found_load;
		logic    sweep_step;
		logic    sweep_fill;
		logic    swap;
		logic    fin;
		logic    fin_ok;
		logic    fin_take;
	} ctl_t;

	typedef struct packed {
		logic is_refill;
		logic is_draw;
		logic is_remove;
		logic count_zero;
		logic value_oor;
		logic value_low;
		logic div_done;
		logic match;
		logic hit;
		logic miss;
		logic sweep_last;
	} sts_t;

endpackage

/* rtl/core/rip_ctrl.sv */
module rip_ctrl import rip_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output ctl_t ctl,
	output logic busy
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		busy    = (state_q != ST_IDLE);
		case (state_q)
			ST_INIT: begin
				ctl.sweep_step = 1'b1;
				if (sts.sweep_last) begin
					ctl.sweep_fill = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					ctl.accept = 1'b1;
					state_d    = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (sts.is_refill) begin
					state_d = ST_REFILL;
				end else if (sts.is_draw) begin
					if (sts.count_zero) begin
						ctl.fin = 1'b1;
						state_d = ST_IDLE;
					end else begin
						ctl.div_load = 1'b1;
						state_d      = ST_DIV;
					end
				end else if (sts.is_remove) begin
					if (sts.value_oor) begin
						ctl.fin = 1'b1;
						state_d = ST_IDLE;
					end else if (sts.value_low) begin
						ctl.load_pos = 1'b1;
						state_d      = ST_RD_POS;
					end else begin
						ctl.scan_init = 1'b1;
						state_d       = ST_SEARCH;
					end
				end else begin
					ctl.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_REFILL: begin
				ctl.sweep_step = 1'b1;
				if (sts.sweep_last) begin
					ctl.sweep_fill = 1'b1;
					ctl.fin        = 1'b1;
					ctl.fin_ok     = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					state_d = ST_RD_POS;
				end else begin
					ctl.div_step = 1'b1;
				end
			end
			ST_RD_POS: begin
				ctl.rd_en  = 1'b1;
				ctl.rd_sel = RD_POS;
				state_d    = ST_CHECK;
			end
			ST_CHECK: begin
				ctl.capture = 1'b1;
				if (sts.is_draw || sts.match) begin
					state_d = ST_FETCH_LAST;
				end else begin
					ctl.scan_init = 1'b1;
					state_d       = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				ctl.rd_en     = 1'b1;
				ctl.rd_sel    = RD_SCAN;
				ctl.scan_step = 1'b1;
				if (sts.hit) begin
					ctl.found_load = 1'b1;
					state_d        = ST_FETCH_LAST;
				end else if (sts.miss) begin
					ctl.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_FETCH_LAST: begin
				ctl.rd_en  = 1'b1;
				ctl.rd_sel = RD_LAST;
				state_d    = ST_WRITE;
			end
			ST_WRITE: begin
				ctl.swap     = 1'b1;
				ctl.fin      = 1'b1;
				ctl.fin_ok   = 1'b1;
				ctl.fin_take = sts.is_draw;
				state_d      = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/rip_datapath.sv */
module rip_datapath import rip_pkg::*; #(
	parameter int POOL_SIZE = POOL_SIZE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ctl_t             ctl,
	output sts_t             sts,
	input  logic [CMD_W-1:0] command,
	input  logic [RND_W-1:0] random_word,
	input  logic [IDX_W-1:0] index_value,
	output logic             done,
	output logic [IDX_W-1:0] drawn_index,
	output logic             ok,
	output logic [REM_W-1:0] remaining,
	output logic             not_empty
);

	localparam int AW   = $clog2(POOL_SIZE);
	localparam int CW   = $clog2(POOL_SIZE + 1);
	localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

	logic [AW-1:0]        pool_q [POOL_SIZE];
	logic [AW-1:0]        rd_data_q;
	logic [AW-1:0]        rd_addr;
	logic [AW-1:0]        sw_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        last_pos;
	logic [CW-1:0]        pos_q;
	logic [CW-1:0]        scan_q;
	logic                 valid_s1;
	logic [CW-1:0]        pos_s1;
	logic [CMD_W-1:0]     cmd_q;
	logic [IDX_W-1:0]     value_q;
	logic [RND_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [AW-1:0]        pick_q;
	logic                 done_q;
	logic                 ok_q;
	logic [IDX_W-1:0]     drawn_q;
	logic [CW:0]          div_trial;
	logic [CW:0]          div_diff;
	logic                 div_fits;
	logic [CMPW-1:0]      value_ext;
	logic [CMPW-1:0]      data_ext;

	assign last_pos  = count_q - CW'(1);
	assign value_ext = CMPW'(value_q);
	assign data_ext  = CMPW'(rd_data_q);
	assign div_trial = {pos_q, quo_q[RND_W-1]};
	assign div_fits  = (div_trial >= {1'b0, count_q});
	assign div_diff  = div_trial - {1'b0, count_q};

	always_comb begin
		case (ctl.rd_sel)
			RD_POS:  rd_addr = pos_q[AW-1:0];
			RD_LAST: rd_addr = last_pos[AW-1:0];
			RD_SCAN: rd_addr = scan_q[AW-1:0];
			default: rd_addr = pos_q[AW-1:0];
		endcase
	end

	always_comb begin
		sts.is_refill  = (cmd_q == CMD_REFILL);
		sts.is_draw    = (cmd_q == CMD_DRAW);
		sts.is_remove  = (cmd_q == CMD_REMOVE);
		sts.count_zero = (count_q == '0);
		sts.value_oor  = (value_ext >= CMPW'(POOL_SIZE));
		sts.value_low  = (value_ext < CMPW'(count_q));
		sts.div_done   = (div_cnt_q == '0);
		sts.match      = (data_ext == value_ext);
		sts.hit        = valid_s1 && (data_ext == value_ext);
		sts.miss       = !valid_s1 && (scan_q >= count_q);
		sts.sweep_last = (sw_q == AW'(POOL_SIZE - 1));
	end

	always_ff @(posedge clk) begin
		if (ctl.sweep_step) begin
			pool_q[sw_q] <= sw_q;
		end else if (ctl.swap) begin
			pool_q[pos_q[AW-1:0]] <= rd_data_q;
		end
		if (ctl.rd_en) begin
			rd_data_q <= pool_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CW'(POOL_SIZE);
			sw_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= ctl.fin;
			if (ctl.sweep_step) begin
				sw_q <= sts.sweep_last ? '0 : sw_q + AW'(1);
			end
			if (ctl.sweep_fill) begin
				count_q <= CW'(POOL_SIZE);
			end else if (ctl.swap) begin
				count_q <= last_pos;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q   <= command;
			value_q <= index_value;
			quo_q   <= random_word;
		end
		if (ctl.div_load) begin
			pos_q     <= '0;
			div_cnt_q <= DIV_CNT_W'(RND_W);
		end else if (ctl.div_step) begin
			pos_q     <= div_fits ? div_diff[CW-1:0] : div_trial[CW-1:0];
			quo_q     <= {quo_q[RND_W-2:0], 1'b0};
			div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
		end else if (ctl.load_pos) begin
			pos_q <= CW'(value_ext);
		end else if (ctl.found_load) begin
			pos_q <= pos_s1;
		end
		if (ctl.scan_init) begin
			scan_q   <= '0;
			valid_s1 <= 1'b0;
		end else if (ctl.scan_step) begin
			valid_s1 <= (scan_q < count_q);
			pos_s1   <= scan_q;
			if (scan_q < count_q) begin
				scan_q <= scan_q + CW'(1);
			end
		end
		if (ctl.capture) begin
			pick_q <= rd_data_q;
		end
		if (ctl.fin) begin
			ok_q    <= ctl.fin_ok;
			drawn_q <= ctl.fin_take ? IDX_W'(pick_q) : '0;
		end
	end

	assign done        = done_q;
	assign ok          = ok_q;
	assign drawn_index = drawn_q;
	assign remaining   = REM_W'(count_q);
	assign not_empty   = (count_q != '0);

endmodule

/* rtl/core/random_index_pool_unit.sv */
// channel   | handshake           | ports
// ----------+---------------------+--------------------------------------------
// command   | start && !busy      | command, random_word, index_value
// result    | done, one cycle     | drawn_index, ok, remaining, not_empty
//
// One transaction at a time; busy stays high from acceptance until the result.
// A draw runs the 31-step restoring modulo unit; a remove reads the slot at the
// index's own position and swaps at once when the index sits there, else scans the
// live pool, one pool read a cycle; a refill sweeps the whole pool; a rejected command
// ends from dispatch. The initialising pass after reset also holds busy high.
// The result strobe cannot be stalled; a new transaction may start in its cycle.
module random_index_pool_unit import rip_pkg::*; #(
	parameter int POOL_SIZE = POOL_SIZE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [CMD_W-1:0] command,
	input  logic [RND_W-1:0] random_word,
	input  logic [IDX_W-1:0] index_value,
	output logic             done,
	output logic [IDX_W-1:0] drawn_index,
	output logic             ok,
	output logic [REM_W-1:0] remaining,
	output logic             not_empty
);

	ctl_t ctl;
	sts_t sts;

	rip_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	rip_datapath #(
		.POOL_SIZE (POOL_SIZE)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.command     (command),
		.random_word (random_word),
		.index_value (index_value),
		.done        (done),
		.drawn_index (drawn_index),
		.ok          (ok),
		.remaining   (remaining),
		.not_empty   (not_empty)
	);

`ifndef SYNTH
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted transaction did not raise busy");

	a_fail_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ok) |-> $stable(remaining))
		else $error("failed transaction changed the pool count");

	a_single_fin: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fin |=> !ctl.fin)
		else $error("two results for one transaction");
`endif

endmodule

/* sim/tb_random_index_pool_unit.sv */
`timescale 1ns / 1ps

module tb_random_index_pool_unit;
	import rip_pkg::*;

	localparam int POOL_N = POOL_SIZE_DEF;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 1000;
	localparam int PHASE_LEN = 200;
	localparam int TAIL_CYCLES = 300;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic [RND_W-1:0] RND_MAX = {RND_W{1'b1}};

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             ok;
		logic [REM_W-1:0] rem;
		logic             ne;
	} pool_result_t;

	class pool_predictor;
		int unsigned  pool_tab[POOL_N];
		int unsigned  live_n;
		pool_result_t due_results[$];
		int           fails;

		function new();
			fails = 0;
			refill();
		endfunction

		function void refill();
			for (int i = 0; i < POOL_N; i++)
				pool_tab[i] = i;
			live_n = POOL_N;
		endfunction

		function void take_out(int unsigned pos);
			if (live_n == 0 || pos >= live_n)
				return;
			pool_tab[pos] = pool_tab[live_n - 1];
			live_n = live_n - 1;
		endfunction

		function void note_command(logic [CMD_W-1:0] cmd, logic [RND_W-1:0] rnd,
				logic [IDX_W-1:0] val);
			pool_result_t r;
			int unsigned  pos;
			r = '0;
			case (cmd)
				CMD_REFILL: begin
					refill();
					r.ok = 1'b1;
				end
				CMD_DRAW: begin
					if (live_n != 0) begin
						pos = rnd % live_n;
						r.idx = IDX_W'(pool_tab[pos]);
						take_out(pos);
						r.ok = 1'b1;
					end
				end
				CMD_REMOVE: begin
					if (val < POOL_N) begin
						for (int i = 0; i < live_n; i++) begin
							if (pool_tab[i] == val) begin
								take_out(i);
								r.ok = 1'b1;
								break;
							end
						end
					end
				end
				default: ;
			endcase
			r.rem = REM_W'(live_n);
			r.ne = (live_n != 0);
			due_results.push_back(r);
		endfunction

		function void flag(string what, logic [31:0] want, logic [31:0] got);
			fails++;
			if (fails <= 10)
				$display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
		endfunction

		function void check_result(pool_result_t got);
			pool_result_t want;
			if (due_results.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("%0t result with no transaction outstanding", $realtime);
				return;
			end
			want = due_results.pop_front();
			if (got.idx !== want.idx)
				flag("drawn_index", 32'(want.idx), 32'(got.idx));
			if (got.ok !== want.ok)
				flag("ok", 32'(want.ok), 32'(got.ok));
			if (got.rem !== want.rem)
				flag("remaining", 32'(want.rem), 32'(got.rem));
			if (got.ne !== want.ne)
				flag("not_empty", 32'(want.ne), 32'(got.ne));
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic [CMD_W-1:0] command = '0;
	logic [RND_W-1:0] random_word = '0;
	logic [IDX_W-1:0] index_value = '0;
	logic             busy;
	logic             done;
	logic [IDX_W-1:0] drawn_index;
	logic             ok;
	logic [REM_W-1:0] remaining;
	logic             not_empty;

	pool_predictor sb = new();
	int            sent_n = 0;
	int            idle_pct = 0;
	int            quiet_cycles = 0;
	int            episode = 0;

	random_index_pool_unit #(.POOL_SIZE(POOL_N)) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.random_word (random_word),
		.index_value (index_value),
		.done        (done),
		.drawn_index (drawn_index),
		.ok          (ok),
		.remaining   (remaining),
		.not_empty   (not_empty)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result('{idx: drawn_index, ok: ok, rem: remaining, ne: not_empty});
	end

	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t watchdog expired", $realtime);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// hold off the next transaction, driving junk on the fields meanwhile
	task automatic idle_gap();
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			command <= CMD_W'($urandom);
			random_word <= RND_W'($urandom);
			index_value <= IDX_W'($urandom);
			@(negedge clk);
		end
	endtask

	task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [RND_W-1:0] rnd,
			input logic [IDX_W-1:0] val);
		start <= 1'b1;
		command <= cmd;
		random_word <= rnd;
		index_value <= val;
		do @(posedge clk); while (busy);
		sb.note_command(cmd, rnd, val);
		sent_n++;
		@(negedge clk);
	endtask

	function automatic logic [RND_W-1:0] pick_word();
		case ($urandom_range(9))
			0: return '0;
			1: return RND_MAX;
			2: return RND_W'($urandom_range(300));
			default: return RND_W'($urandom);
		endcase
	endfunction

	function automatic logic [IDX_W-1:0] pick_live();
		if (sb.live_n == 0)
			return IDX_W'($urandom);
		return IDX_W'(sb.pool_tab[$urandom_range(sb.live_n - 1)]);
	endfunction

	task automatic random_command(input bit draining);
		logic [CMD_W-1:0] cmd;
		logic [IDX_W-1:0] val;
		int unsigned      roll;
		roll = $urandom_range(99);
		val = IDX_W'($urandom);
		if (draining) begin
			cmd = (roll < 60) ? CMD_DRAW : CMD_REMOVE;
			if (cmd == CMD_REMOVE && roll < 90)
				val = pick_live();
		end else if (roll < 45) begin
			cmd = CMD_DRAW;
		end else if (roll < 70) begin
			cmd = CMD_REMOVE;
			val = pick_live();
		end else if (roll < 88) begin
			cmd = CMD_REMOVE;
		end else if (roll < 95) begin
			cmd = CMD_UNUSED;
		end else begin
			cmd = CMD_REFILL;
		end
		case ((sent_n / PHASE_LEN) % 4)
			0: idle_pct = 0;
			1: idle_pct = 49;
			2: idle_pct = 22;
			default: idle_pct = 0;
		endcase
		idle_gap();
		send_command(cmd, pick_word(), val);
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_command(CMD_DRAW, '0, 8'd0);
		send_command(CMD_DRAW, RND_MAX, 8'd0);
		send_command(CMD_REMOVE, RND_MAX, 8'd5);
		send_command(CMD_REMOVE, '0, 8'd5);
		send_command(CMD_REMOVE, '0, 8'd255);
		send_command(CMD_REMOVE, '0, 8'd0);
		send_command(CMD_REMOVE, '0, 8'd128);
		send_command(CMD_UNUSED, RND_MAX, 8'hFF);
		send_command(CMD_REFILL, RND_MAX, 8'hFF);
		send_command(CMD_REMOVE, '0, 8'd0);
		send_command(CMD_REMOVE, '0, 8'd255);
		send_command(CMD_DRAW, RND_W'(1), 8'd0);
		send_command(CMD_DRAW, RND_W'(31'h4000_0000), 8'd0);
		send_command(CMD_REMOVE, RND_W'(31'h2AAA_AAAA), 8'hAA);
		send_command(CMD_REMOVE, RND_W'(31'h5555_5555), 8'h55);
		send_command(CMD_REFILL, '0, 8'd0);
		send_command(CMD_DRAW, RND_W'(255), 8'd0);
		send_command(CMD_DRAW, RND_W'(256), 8'd0);
		send_command(CMD_UNUSED, '0, 8'd0);

		sent_n = 0;
		while (sent_n < RANDOM_ITEMS) begin
			random_command(1'b0);
			if (episode % 4 == 1) begin
				while (sb.live_n != 0)
					random_command(1'b1);
				repeat ($urandom_range(2, 4))
					random_command(1'b1);
				random_command(1'b0);
			end else begin
				repeat ($urandom_range(1, 60))
					random_command(1'b0);
			end
			idle_gap();
			send_command(CMD_REFILL, pick_word(), IDX_W'($urandom));
			episode++;
		end

		start <= 1'b0;
		while (sb.due_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.due_results.size() != 0)
			$display("%0d results never arrived", sb.due_results.size());
		if (sb.fails == 0 && sb.due_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
